[rtl/wrapping_text_console_writer_unit_defines.svh]
// Assertion macros for the console writer RTL.
`ifndef WRAPPING_TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH
`define WRAPPING_TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define WTC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define WTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/wtc_pkg.sv]
package wtc_pkg;

  // Default screen geometry.
  localparam int COLUMNS_DEF   = 80;
  localparam int ROWS_DEF      = 25;
  localparam int TAB_WIDTH_DEF = 8;

  // Fixed field widths.
  localparam int IDX_W   = 11;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 4;

  // Control characters that move the cursor.
  localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

  // Glyph used to blank a row.
  localparam logic [CHAR_W-1:0] BLANK_GLYPH = 8'h20;

  // Write kinds of a result word.
  localparam logic KIND_CELL = 1'b0;
  localparam logic KIND_FILL = 1'b1;

  // One result word plus a flag telling whether the byte produced one.
  typedef struct packed {
    logic                  has_result;
    logic                  write_kind;
    logic [IDX_W-1:0]      cell_index;
    logic [CHAR_W-1:0]     glyph;
    logic [2*COLOR_W-1:0]  attribute;
    logic [IDX_W-1:0]      cursor_pos;
  } result_t;

endpackage

[rtl/wrapping_text_console_writer_unit.sv]
// Channel   Handshake             Payload
// input     in_valid / in_stall   char_code, home, fg, bg
// output    out_valid / out_stall write_kind, cell_index, glyph, attribute, cursor_pos
//
// One byte is taken per cycle while in_stall is low; it goes to the input register and its
// result word to the result register. The rate is set by the cursor update between them.
// Bytes that move the cursor without writing give no word.
// Reset (rst, synchronous) puts the cursor at row 0, column 0 and clears the wrap flag.
// A stalled result word holds; the input register stalls only while it is full behind it.
`include "wrapping_text_console_writer_unit_defines.svh"

module wrapping_text_console_writer_unit #(
  parameter int COLUMNS   = wtc_pkg::COLUMNS_DEF,
  parameter int ROWS      = wtc_pkg::ROWS_DEF,
  parameter int TAB_WIDTH = wtc_pkg::TAB_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [wtc_pkg::CHAR_W-1:0]    char_code,
  input  logic                          home,
  input  logic [wtc_pkg::COLOR_W-1:0]   fg,
  input  logic [wtc_pkg::COLOR_W-1:0]   bg,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          write_kind,
  output logic [wtc_pkg::IDX_W-1:0]     cell_index,
  output logic [wtc_pkg::CHAR_W-1:0]    glyph,
  output logic [2*wtc_pkg::COLOR_W-1:0] attribute,
  output logic [wtc_pkg::IDX_W-1:0]     cursor_pos
);
  import wtc_pkg::*;

  localparam int CW = $clog2(COLUMNS);
  localparam int RW = $clog2(ROWS);

  logic                in_full;
  logic [CHAR_W-1:0]   char_q;
  logic                home_q;
  logic [COLOR_W-1:0]  fg_q;
  logic [COLOR_W-1:0]  bg_q;
  logic [CW-1:0]       cursor_col;
  logic [RW-1:0]       cursor_row;
  logic                has_wrapped;
  logic [CW-1:0]       col_next;
  logic [RW-1:0]       row_next;
  logic                set_wrap;
  result_t             res;
  logic                adv;
  logic                process;

  // The word in the input register moves on whenever the result slot is free.
  assign adv      = !out_valid || !out_stall;
  assign process  = in_full && adv;
  assign in_stall = in_full && !adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
    if (in_valid && !in_stall) begin
      char_q <= char_code;
      home_q <= home;
      fg_q   <= fg;
      bg_q   <= bg;
    end
  end

  wtc_step #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_step (
    .col       (cursor_col),
    .row       (cursor_row),
    .wrapped   (has_wrapped),
    .char_code (char_q),
    .home      (home_q),
    .fg        (fg_q),
    .bg        (bg_q),
    .col_next  (col_next),
    .row_next  (row_next),
    .set_wrap  (set_wrap),
    .res       (res)
  );

  // Cursor state advances once per processed byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col  <= '0;
      cursor_row  <= '0;
      has_wrapped <= 1'b0;
    end else if (process) begin
      cursor_col  <= col_next;
      cursor_row  <= row_next;
      has_wrapped <= has_wrapped | set_wrap;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= process && res.has_result;
    end
    if (process && res.has_result) begin
      write_kind <= res.write_kind;
      cell_index <= res.cell_index;
      glyph      <= res.glyph;
      attribute  <= res.attribute;
      cursor_pos <= res.cursor_pos;
    end
  end

  // Checks on the cursor state and the flow control.
  `WTC_ASSERT_NEXT(a_wrap_sticky, has_wrapped, has_wrapped, "wrap flag was cleared")
  `WTC_ASSERT_NOW(a_cursor_range, 1'b1,
    ({1'b0, cursor_col} < (CW+1)'(COLUMNS)) && ({1'b0, cursor_row} < (RW+1)'(ROWS)),
    "cursor left the screen")
  `WTC_ASSERT_NOW(a_fill_after_wrap, out_valid && (write_kind == KIND_FILL), has_wrapped, "row fill before any wrap")
  `WTC_ASSERT_NOW(a_stall_cause, in_stall, in_full && out_valid && out_stall, "input stalled with a free result slot")

endmodule

[rtl/wtc_step.sv]
module wtc_step #(
  parameter int COLUMNS   = wtc_pkg::COLUMNS_DEF,
  parameter int ROWS      = wtc_pkg::ROWS_DEF,
  parameter int TAB_WIDTH = wtc_pkg::TAB_WIDTH_DEF
) (
  input  logic [$clog2(COLUMNS)-1:0]     col,
  input  logic [$clog2(ROWS)-1:0]        row,
  input  logic                           wrapped,
  input  logic [wtc_pkg::CHAR_W-1:0]     char_code,
  input  logic                           home,
  input  logic [wtc_pkg::COLOR_W-1:0]    fg,
  input  logic [wtc_pkg::COLOR_W-1:0]    bg,
  output logic [$clog2(COLUMNS)-1:0]     col_next,
  output logic [$clog2(ROWS)-1:0]        row_next,
  output logic                           set_wrap,
  output wtc_pkg::result_t               res
);
  import wtc_pkg::*;

  localparam int CW  = $clog2(COLUMNS);
  localparam int RW  = $clog2(ROWS);
  localparam int CAW = $clog2(COLUMNS + TAB_WIDTH);
  localparam int RAW = $clog2(ROWS + 1);
  localparam int PW  = $clog2(ROWS * COLUMNS + 1);

  logic [CAW-1:0] tab_tbl [2**CW];
  logic [CW-1:0]  col0;
  logic [RW-1:0]  row0;
  logic [CAW-1:0] col_a;
  logic [RAW-1:0] row_a;
  logic           lf;
  logic           prn;
  logic [PW-1:0]  cell_w;
  logic [PW-1:0]  fill_w;

  // Next tab stop for every column, worked out at elaboration.
  for (genvar g = 0; g < 2**CW; g++) begin : g_tab
    assign tab_tbl[g] = CAW'(g + TAB_WIDTH - (g % TAB_WIDTH));
  end

  // Cursor movement for the byte, then column wrap, then row wrap.
  always_comb begin
    col0  = home ? '0 : col;
    row0  = home ? '0 : row;
    col_a = CAW'(col0);
    row_a = RAW'(row0);
    lf    = 1'b0;
    prn   = 1'b0;
    priority if (char_code == CH_BS) begin
      if (col0 != '0) begin
        col_a = CAW'(col0) - CAW'(1);
      end
    end else if (char_code == CH_TAB) begin
      col_a = tab_tbl[col0];
    end else if (char_code == CH_CR) begin
      col_a = '0;
    end else if (char_code == CH_LF) begin
      col_a = '0;
      row_a = RAW'(row0) + RAW'(1);
      lf    = 1'b1;
    end else if (!char_code[7] && (char_code[6:5] != 2'b00)) begin
      prn   = 1'b1;
      col_a = CAW'(col0) + CAW'(1);
    end else begin
      prn = 1'b0;
    end

    if (col_a >= CAW'(COLUMNS)) begin
      col_a = '0;
      row_a = row_a + RAW'(1);
    end

    set_wrap = (row_a >= RAW'(ROWS));
    if (set_wrap) begin
      col_a = '0;
      row_a = '0;
    end

    col_next = col_a[CW-1:0];
    row_next = row_a[RW-1:0];
  end

  // Cell address of the written character and start of the filled row.
  assign cell_w = PW'(row0) * PW'(COLUMNS) + PW'(col0);
  assign fill_w = PW'(row_next) * PW'(COLUMNS);

  // Result word: a row fill for a line feed after the screen has wrapped, or a cell write for a printable byte.
  always_comb begin
    res.has_result = 1'b0;
    res.write_kind = KIND_CELL;
    res.cell_index = IDX_W'(cell_w);
    res.glyph      = char_code;
    res.attribute  = {bg, fg};
    res.cursor_pos = IDX_W'(cell_w + PW'(1));
    if (lf && wrapped) begin
      res.has_result = 1'b1;
      res.write_kind = KIND_FILL;
      res.cell_index = IDX_W'(fill_w);
      res.glyph      = BLANK_GLYPH;
      res.cursor_pos = IDX_W'(fill_w + PW'(COLUMNS));
    end else if (prn) begin
      res.has_result = 1'b1;
    end
  end

endmodule

[tb/sv/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wtc_pkg::*;

  localparam int COLUMNS   = COLUMNS_DEF;
  localparam int ROWS      = ROWS_DEF;
  localparam int TAB_WIDTH = TAB_WIDTH_DEF;

  // Printable byte range.
  localparam logic [CHAR_W-1:0] PRINT_LO = 8'h20;
  localparam logic [CHAR_W-1:0] PRINT_HI = 8'h7F;

  localparam int RANDOM_CHARS   = 430;
  localparam int PRESSURE_START = 320;
  localparam int PRESSURE_HOLD  = 80;
  localparam int DRAIN_CYCLES   = 8;
  localparam int CYCLE_LIMIT    = 200000;

  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic               home;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
  } char_item_t;

  typedef struct packed {
    logic                 kind;
    logic [IDX_W-1:0]     index;
    logic [CHAR_W-1:0]    glyph;
    logic [2*COLOR_W-1:0] attr;
    logic [IDX_W-1:0]     cursor;
  } cell_write_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CHAR_W-1:0]    char_code = '0;
  logic                 home = 1'b0;
  logic [COLOR_W-1:0]   fg = '0;
  logic [COLOR_W-1:0]   bg = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 write_kind;
  logic [IDX_W-1:0]     cell_index;
  logic [CHAR_W-1:0]    glyph;
  logic [2*COLOR_W-1:0] attribute;
  logic [IDX_W-1:0]     cursor_pos;

  char_item_t  char_queue[$];
  cell_write_t expected_writes[$];

  // Predicted cursor state of the console.
  int unsigned cursor_col  = 0;
  int unsigned cursor_row  = 0;
  bit          has_wrapped = 1'b0;

  int unsigned words_sent    = 0;
  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;
  int unsigned hold_left     = 0;
  bit          pressure_done = 1'b0;

  wrapping_text_console_writer_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .char_code  (char_code),
    .home       (home),
    .fg         (fg),
    .bg         (bg),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .write_kind (write_kind),
    .cell_index (cell_index),
    .glyph      (glyph),
    .attribute  (attribute),
    .cursor_pos (cursor_pos)
  );

  always #5 clk = ~clk;

  // Idle percentage of each side, by how far the stimulus has gone.
  function automatic int unsigned idle_pct(input int unsigned sent, input bit rx_side);
    if (sent < 150) begin
      return rx_side ? 54 : 18;
    end else if (sent < 300) begin
      return rx_side ? 18 : 54;
    end
    return 0;
  endfunction

  // Moves the predicted cursor for one byte; returns 1 when a write word is due.
  function automatic bit advance_cursor(input char_item_t it, output cell_write_t w);
    int unsigned col;
    int unsigned row;
    int unsigned cell_addr;
    bit          line_feed;
    bit          emit;
    bit          was_wrapped;
    logic [2*COLOR_W-1:0] attr;
    w           = '0;
    emit        = 1'b0;
    line_feed   = 1'b0;
    was_wrapped = has_wrapped;
    attr        = {it.bg, it.fg};
    if (it.home) begin
      cursor_col = 0;
      cursor_row = 0;
    end
    col = cursor_col;
    row = cursor_row;

    // Cursor motion or a single cell write.
    if (it.ch == CH_BS) begin
      if (col != 0) col = col - 1;
    end else if (it.ch == CH_TAB) begin
      col = col + TAB_WIDTH - (col % TAB_WIDTH);
    end else if (it.ch == CH_CR) begin
      col = 0;
    end else if (it.ch == CH_LF) begin
      col       = 0;
      row       = row + 1;
      line_feed = 1'b1;
    end else if (it.ch >= PRINT_LO && it.ch <= PRINT_HI) begin
      cell_addr = row * COLUMNS + col;
      w.kind    = KIND_CELL;
      w.index   = cell_addr[IDX_W-1:0];
      w.glyph   = it.ch;
      w.attr    = attr;
      w.cursor  = IDX_W'(cell_addr + 1);
      emit      = 1'b1;
      col       = col + 1;
    end

    // Column wrap, then row wrap.
    if (col >= COLUMNS) begin
      col = 0;
      row = row + 1;
    end
    if (row >= ROWS) begin
      col         = 0;
      row         = 0;
      has_wrapped = 1'b1;
    end

    // After the screen has wrapped once, a line feed blanks the row it lands on.
    if (line_feed && was_wrapped) begin
      cell_addr = row * COLUMNS;
      w.kind    = KIND_FILL;
      w.index   = cell_addr[IDX_W-1:0];
      w.glyph   = BLANK_GLYPH;
      w.attr    = attr;
      w.cursor  = IDX_W'(cell_addr + COLUMNS);
      emit      = 1'b1;
    end
    cursor_col = col & 32'h7F;
    cursor_row = row & 32'h1F;
    return emit;
  endfunction

  task automatic queue_char(input logic [CHAR_W-1:0] ch, input logic hm,
                            input logic [COLOR_W-1:0] f, input logic [COLOR_W-1:0] b);
    char_item_t it;
    it.ch   = ch;
    it.home = hm;
    it.fg   = f;
    it.bg   = b;
    char_queue.push_back(it);
  endtask

  // Mostly text and line feeds, with controls, ignored bytes and raw noise mixed in.
  function automatic logic [CHAR_W-1:0] random_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 48) return PRINT_LO + CHAR_W'($urandom_range(0, PRINT_HI - PRINT_LO));
    if (r < 68) return CH_LF;
    if (r < 76) return CH_TAB;
    if (r < 80) return CH_CR;
    if (r < 85) return CH_BS;
    if (r < 89) begin
      case ($urandom_range(0, 4))
        0:       return CHAR_W'($urandom_range(0, 7));
        1:       return 8'h0B;
        2:       return 8'h0C;
        3:       return CHAR_W'($urandom_range(8'h0E, 8'h1F));
        default: return CHAR_W'($urandom_range(8'h80, 8'hFF));
      endcase
    end
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  // Driver: offers queued words and predicts each one at acceptance.
  always @(posedge clk) begin
    bit          taken;
    bit          emit;
    cell_write_t w;
    char_item_t  it;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      taken = in_valid && !in_stall;
      if (taken) begin
        it.ch   = char_code;
        it.home = home;
        it.fg   = fg;
        it.bg   = bg;
        emit    = advance_cursor(it, w);
        if (emit) expected_writes.push_back(w);
      end
      if (!in_valid || taken) begin
        if (char_queue.size() != 0 &&
            $urandom_range(0, 99) >= idle_pct(words_sent, 1'b0)) begin
          it = char_queue.pop_front();
          char_code  <= it.ch;
          home       <= it.home;
          fg         <= it.fg;
          bg         <= it.bg;
          in_valid   <= 1'b1;
          words_sent <= words_sent + 1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result word against the oldest prediction.
  always @(posedge clk) begin
    cell_write_t w;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_writes.size() == 0) begin
          $display("%0t: unexpected word kind %0d index %0d glyph %h attr %h cursor %0d",
                   $time, write_kind, cell_index, glyph, attribute, cursor_pos);
          error_count = error_count + 1;
        end else begin
          w = expected_writes.pop_front();
          if (write_kind !== w.kind) begin
            $display("%0t: write_kind expected %0d, got %0d", $time, w.kind, write_kind);
            error_count = error_count + 1;
          end
          if (cell_index !== w.index) begin
            $display("%0t: cell_index expected %0d, got %0d", $time, w.index, cell_index);
            error_count = error_count + 1;
          end
          if (glyph !== w.glyph) begin
            $display("%0t: glyph expected %h, got %h", $time, w.glyph, glyph);
            error_count = error_count + 1;
          end
          if (attribute !== w.attr) begin
            $display("%0t: attribute expected %h, got %h", $time, w.attr, attribute);
            error_count = error_count + 1;
          end
          if (cursor_pos !== w.cursor) begin
            $display("%0t: cursor_pos expected %0d, got %0d", $time, w.cursor, cursor_pos);
            error_count = error_count + 1;
          end
        end
      end

      // A long hold-off once the sender runs freely, so the block backs up.
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!pressure_done && words_sent >= PRESSURE_START) begin
        out_stall     <= 1'b1;
        hold_left     <= PRESSURE_HOLD;
        pressure_done <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < idle_pct(words_sent, 1'b1));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    // Field extremes and cursor motion on the first rows.
    queue_char(PRINT_LO, 1'b0, 4'h0, 4'h0);
    queue_char(PRINT_HI, 1'b0, 4'hF, 4'hF);
    queue_char(CH_BS,    1'b0, 4'h5, 4'hA);
    queue_char(CH_BS,    1'b0, 4'hA, 4'h5);
    queue_char(CH_BS,    1'b0, 4'h1, 4'h2);  // backspace at column zero
    queue_char(CH_TAB,   1'b0, 4'h3, 4'h4);
    queue_char(8'h41,    1'b0, 4'hC, 4'h3);
    queue_char(CH_TAB,   1'b0, 4'h0, 4'hF);
    queue_char(CH_CR,    1'b0, 4'hF, 4'h0);
    queue_char(CH_LF,    1'b0, 4'h7, 4'h8);
    // Ignored bytes.
    queue_char(8'h00,    1'b0, 4'hF, 4'hF);
    queue_char(8'h07,    1'b0, 4'h1, 4'h1);
    queue_char(8'h0B,    1'b0, 4'h2, 4'h2);
    queue_char(8'h0C,    1'b0, 4'h3, 4'h3);
    queue_char(8'h0E,    1'b0, 4'h4, 4'h4);
    queue_char(8'h1F,    1'b0, 4'h5, 4'h5);
    queue_char(8'h80,    1'b0, 4'h6, 4'h6);
    queue_char(8'hFF,    1'b1, 4'h7, 4'h7);
    // Home ahead of a write and ahead of a backspace.
    queue_char(8'h5A,    1'b1, 4'h9, 4'h6);
    queue_char(CH_BS,    1'b1, 4'hE, 4'h1);
    for (int i = 0; i < RANDOM_CHARS; i++) begin
      queue_char(random_char(), ($urandom_range(0, 199) == 0),
                 COLOR_W'($urandom_range(0, 15)), COLOR_W'($urandom_range(0, 15)));
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Wait for the last word to be taken and its result to arrive.
    do begin
      @(posedge clk);
    end while (char_queue.size() != 0 || in_valid || expected_writes.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
